// ----- hdl/ccl_pkg.sv -----
package ccl_pkg;

  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_LABELS = 4096;

  localparam int CLASS_W   = 8;
  localparam int LABEL_W   = 12;
  localparam int HCFG_W    = 10;
  localparam int WCFG_W    = 11;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(512);
  localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(1024);

  // register index, taken from paddr[2]
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  typedef enum logic [1:0] {
    PH_ORIGIN,
    PH_ROW0,
    PH_COL0,
    PH_INNER
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   row1;
    logic   fend;
  } scan_ctl_t;

  typedef struct packed {
    logic [LABEL_W-1:0] pixel_label;
    logic               new_label;
    logic               merge_valid;
    logic [LABEL_W-1:0] merge_from;
    logic [LABEL_W-1:0] merge_to;
    logic [LABEL_W-1:0] label_count;
    logic               label_overflow;
    logic               frame_end;
  } res_t;

endpackage

// ----- hdl/ccl_ram.sv -----
module ccl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // a read at the address written in the same cycle returns the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/ccl_scan.sv -----
module ccl_scan
  import ccl_pkg::*;
#(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          accept_i,
  output scan_ctl_t                     ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  x_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] y_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [HCFG_W-1:0] height_q;
  logic [WCFG_W-1:0] width_q;
  logic              wr_en;
  logic              reg_idx;

  phase_e          phase_q, phase_d;
  logic [XW-1:0]   x_q, x_d;
  logic [YW-1:0]   y_q, y_d;
  logic [WW-1:0]   w_eff, x_inc;
  logic [HW-1:0]   h_eff, y_inc;
  logic            w_gt1, h_gt1, x_more, y_more, fend;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RST;
      width_q  <= WIDTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEIGHT: height_q <= pwdata[HCFG_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      default:    prdata = '0;
    endcase
  end

  // zero counts as one, anything above the maximum saturates
  always_comb begin
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
  end

  assign x_inc  = WW'(x_q) + WW'(1);
  assign y_inc  = HW'(y_q) + HW'(1);
  assign w_gt1  = w_eff > WW'(1);
  assign h_gt1  = h_eff > HW'(1);
  assign x_more = x_inc < w_eff;
  assign y_more = y_inc < h_eff;

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    fend    = 1'b0;
    unique case (phase_q)
      PH_ORIGIN: begin
        if (w_gt1) begin
          phase_d = PH_ROW0;
          x_d     = XW'(1);
          y_d     = '0;
        end else if (h_gt1) begin
          phase_d = PH_COL0;
          x_d     = '0;
          y_d     = YW'(1);
        end else begin
          fend = 1'b1;
        end
      end
      PH_ROW0: begin
        if (x_more) begin
          x_d = XW'(x_inc);
        end else if (h_gt1) begin
          phase_d = PH_COL0;
          x_d     = '0;
          y_d     = YW'(1);
        end else begin
          fend = 1'b1;
        end
      end
      PH_COL0: begin
        if (y_more) begin
          y_d = YW'(y_inc);
        end else if (w_gt1) begin
          phase_d = PH_INNER;
          x_d     = XW'(1);
          y_d     = YW'(1);
        end else begin
          fend = 1'b1;
        end
      end
      PH_INNER: begin
        if (y_more) begin
          y_d = YW'(y_inc);
        end else if (x_more) begin
          x_d = XW'(x_inc);
          y_d = YW'(1);
        end else begin
          fend = 1'b1;
        end
      end
      default: ;
    endcase
    if (fend) begin
      phase_d = PH_ORIGIN;
      x_d     = '0;
      y_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ORIGIN;
      x_q     <= '0;
      y_q     <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  assign ctl_o.phase = phase_q;
  assign ctl_o.row1  = (y_q == YW'(1));
  assign ctl_o.fend  = fend;
  assign x_o         = x_q;
  assign y_o         = y_q;

endmodule

// ----- hdl/ccl_label.sv -----
module ccl_label
  import ccl_pkg::*;
#(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_LABELS = DEF_MAX_LABELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [CLASS_W-1:0]            cls_i,
  input  scan_ctl_t                     ctl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  x_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] y_i,
  output logic                          push_o,
  output res_t                          res_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int LW = $clog2(MAX_LABELS);
  localparam int DW = CLASS_W + LW;
  localparam logic [LW-1:0] LAST_LABEL = LW'(MAX_LABELS - 1);

  logic               s1_v_q;
  scan_ctl_t          s1_ctl_q;
  logic [XW-1:0]      s1_x_q;
  logic [YW-1:0]      s1_y_q;
  logic [CLASS_W-1:0] s1_cls_q;

  logic [CLASS_W-1:0] above_cls_q;
  logic [LW-1:0]      above_lab_q;
  logic [LW-1:0]      next_label_q, next_label_d;
  logic               ovf_q, ovf_d;

  logic               fwd_top_q, fwd_col_q;
  logic [DW-1:0]      fwd_top_data_q, fwd_col_data_q;

  logic               top_we, col_we;
  logic [DW-1:0]      wdata, top_rdata, col_rdata, top_nb, col_nb;
  logic [CLASS_W-1:0] top_cls, col_cls, t_cls;
  logic [LW-1:0]      top_lab, col_lab, t_lab;

  logic [LW-1:0]      n_base, alloc_lab, lab, lo, hi;
  logic               ov_base, can_alloc, need_alloc, fresh, mv, ml, mt;

  ccl_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (s1_x_q),
    .wdata_i (wdata),
    .re_i    (accept_i),
    .raddr_i (x_i),
    .rdata_o (top_rdata)
  );

  ccl_ram #(.WIDTH(DW), .DEPTH(MAX_HEIGHT)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (s1_y_q),
    .wdata_i (wdata),
    .re_i    (accept_i),
    .raddr_i (y_i),
    .rdata_o (col_rdata)
  );

  // bypass a write that lands on the entry read in the same cycle
  assign top_nb  = fwd_top_q ? fwd_top_data_q : top_rdata;
  assign col_nb  = fwd_col_q ? fwd_col_data_q : col_rdata;
  assign top_cls = top_nb[DW-1 -: CLASS_W];
  assign top_lab = top_nb[LW-1:0];
  assign col_cls = col_nb[DW-1 -: CLASS_W];
  assign col_lab = col_nb[LW-1:0];

  // upper neighbor: row 0 comes from the top store, else the previous pixel
  assign t_cls = s1_ctl_q.row1 ? top_cls : above_cls_q;
  assign t_lab = s1_ctl_q.row1 ? top_lab : above_lab_q;

  // the origin pixel restarts the count
  assign n_base    = (s1_ctl_q.phase == PH_ORIGIN) ? '0 : next_label_q;
  assign ov_base   = (s1_ctl_q.phase == PH_ORIGIN) ? 1'b0 : ovf_q;
  assign can_alloc = n_base < LAST_LABEL;
  assign alloc_lab = can_alloc ? n_base + LW'(1) : LAST_LABEL;

  assign ml = (s1_cls_q == col_cls);
  assign mt = (s1_cls_q == t_cls);
  assign lo = (col_lab < t_lab) ? col_lab : t_lab;
  assign hi = (col_lab < t_lab) ? t_lab : col_lab;

  always_comb begin
    need_alloc = 1'b0;
    lab        = '0;
    mv         = 1'b0;
    unique case (s1_ctl_q.phase)
      PH_ORIGIN: need_alloc = 1'b1;
      PH_ROW0: begin
        if (s1_cls_q == above_cls_q) begin
          lab = above_lab_q;
        end else begin
          need_alloc = 1'b1;
        end
      end
      PH_COL0: begin
        if (mt) begin
          lab = t_lab;
        end else begin
          need_alloc = 1'b1;
        end
      end
      PH_INNER: begin
        if (ml && mt) begin
          lab = lo;
          mv  = (col_lab != t_lab);
        end else if (ml) begin
          lab = col_lab;
        end else if (mt) begin
          lab = t_lab;
        end else begin
          need_alloc = 1'b1;
        end
      end
      default: ;
    endcase
    if (need_alloc) begin
      lab          = alloc_lab;
      fresh        = can_alloc;
      next_label_d = alloc_lab;
      ovf_d        = ov_base || !can_alloc;
    end else begin
      fresh        = 1'b0;
      next_label_d = n_base;
      ovf_d        = ov_base;
    end
  end

  assign wdata  = {s1_cls_q, lab};
  assign top_we = s1_v_q &&
                  (s1_ctl_q.phase == PH_ORIGIN || s1_ctl_q.phase == PH_ROW0);
  assign col_we = s1_v_q && (s1_ctl_q.phase != PH_ROW0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s1_ctl_q     <= '{phase: PH_ORIGIN, row1: 1'b0, fend: 1'b0};
      fwd_top_q    <= 1'b0;
      fwd_col_q    <= 1'b0;
      above_cls_q  <= '0;
      above_lab_q  <= '0;
      next_label_q <= '0;
      ovf_q        <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      if (accept_i) begin
        s1_ctl_q  <= ctl_i;
        fwd_top_q <= top_we && (s1_x_q == x_i);
        fwd_col_q <= col_we && (s1_y_q == y_i);
      end
      if (s1_v_q) begin
        above_cls_q  <= s1_cls_q;
        above_lab_q  <= lab;
        next_label_q <= next_label_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_x_q         <= x_i;
      s1_y_q         <= y_i;
      s1_cls_q       <= cls_i;
      fwd_top_data_q <= wdata;
      fwd_col_data_q <= wdata;
    end
  end

  assign push_o               = s1_v_q;
  assign res_o.pixel_label    = LABEL_W'(lab);
  assign res_o.new_label      = fresh;
  assign res_o.merge_valid    = mv;
  assign res_o.merge_from     = mv ? LABEL_W'(hi) : '0;
  assign res_o.merge_to       = mv ? LABEL_W'(lo) : '0;
  assign res_o.label_count    = LABEL_W'(next_label_d);
  assign res_o.label_overflow = ovf_d;
  assign res_o.frame_end      = s1_ctl_q.fend;

endmodule

// ----- hdl/ccl_obuf.sv -----
module ccl_obuf
  import ccl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t res_o,
  output logic in_stall_o
);

  logic [1:0] cnt_q;
  logic [2:0] level;
  logic       pop;
  res_t       ent0_q, ent1_q;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign level       = 3'(cnt_q) + 3'(push_i) - 3'(pop);
  // an item taken now lands here in the next cycle, so keep one slot free
  assign in_stall_o  = level > 3'd1;
  assign res_o       = ent0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= level[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd1) begin
        ent0_q <= res_i;
      end else begin
        ent0_q <= ent1_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        ent1_q <= res_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= res_i;
      end else begin
        ent1_q <= res_i;
      end
    end
  end

endmodule

// ----- hdl/connected_component_label_pass.sv -----
// Pipeline: a transferred pixel reads the neighbor stores as it is taken, its label
//   decision is registered into the output buffer, and its result shows on the output
//   from then on until it transfers out. Throughput: one pixel per cycle while the
//   output buffer does not stall the input, set by the single read port of each
//   neighbor store; a write to the entry being read is bypassed.
// Reset: asynchronous, clears scan position, label count, buffer; size 512 x 1024.
module connected_component_label_pass
  import ccl_pkg::*;
#(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_LABELS = DEF_MAX_LABELS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CLASS_W-1:0]  pixel_class_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LABEL_W-1:0]  pixel_label_o,
  output logic                new_label_o,
  output logic                merge_valid_o,
  output logic [LABEL_W-1:0]  merge_from_o,
  output logic [LABEL_W-1:0]  merge_to_o,
  output logic [LABEL_W-1:0]  label_count_o,
  output logic                label_overflow_o,
  output logic                frame_end_o
);

  logic                          accept;
  logic                          push;
  scan_ctl_t                     ctl;
  logic [$clog2(MAX_WIDTH)-1:0]  x;
  logic [$clog2(MAX_HEIGHT)-1:0] y;
  res_t                          res, head;

  assign accept = in_valid_i && !in_stall_o;

  ccl_scan #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .accept_i (accept),
    .ctl_o    (ctl),
    .x_o      (x),
    .y_o      (y)
  );

  ccl_label #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LABELS(MAX_LABELS)
  ) u_label (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cls_i    (pixel_class_i),
    .ctl_i    (ctl),
    .x_i      (x),
    .y_i      (y),
    .push_o   (push),
    .res_o    (res)
  );

  ccl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (head),
    .in_stall_o  (in_stall_o)
  );

  assign pixel_label_o    = head.pixel_label;
  assign new_label_o      = head.new_label;
  assign merge_valid_o    = head.merge_valid;
  assign merge_from_o     = head.merge_from;
  assign merge_to_o       = head.merge_to;
  assign label_count_o    = head.label_count;
  assign label_overflow_o = head.label_overflow;
  assign frame_end_o      = head.frame_end;

endmodule

// ----- hdl/ccl_checker.sv -----
module ccl_checker
  import ccl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LABEL_W-1:0] pixel_label_o,
  input logic               new_label_o,
  input logic               merge_valid_o,
  input logic [LABEL_W-1:0] merge_from_o,
  input logic [LABEL_W-1:0] merge_to_o,
  input logic [LABEL_W-1:0] label_count_o,
  input logic               label_overflow_o,
  input logic               frame_end_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_label_o) &&
      $stable(frame_end_o) && $stable(label_count_o))
    else $error("stalled result changed");

  // a merge maps the larger label onto the smaller one the pixel takes
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merge_valid_o |->
      merge_from_o > merge_to_o && pixel_label_o == merge_to_o && !new_label_o)
    else $error("bad equivalence record");

  // a fresh label is the newest one counted and never comes from saturation
  a_fresh_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_label_o |->
      pixel_label_o == label_count_o && !label_overflow_o)
    else $error("fresh label does not match the count");

endmodule

bind connected_component_label_pass ccl_checker u_ccl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .pixel_label_o    (pixel_label_o),
  .new_label_o      (new_label_o),
  .merge_valid_o    (merge_valid_o),
  .merge_from_o     (merge_from_o),
  .merge_to_o       (merge_to_o),
  .label_count_o    (label_count_o),
  .label_overflow_o (label_overflow_o),
  .frame_end_o      (frame_end_o)
);

// ----- tb/sv/connected_component_label_pass_test.sv -----
module connected_component_label_pass_test;
  import ccl_pkg::*;

  class label_scoreboard;
    int unsigned        height_reg;
    int unsigned        width_reg;
    logic [CLASS_W-1:0] top_cls [DEF_MAX_WIDTH];
    logic [LABEL_W-1:0] top_lbl [DEF_MAX_WIDTH];
    logic [CLASS_W-1:0] col_cls [DEF_MAX_HEIGHT];
    logic [LABEL_W-1:0] col_lbl [DEF_MAX_HEIGHT];
    logic [CLASS_W-1:0] prev_cls;
    logic [LABEL_W-1:0] prev_lbl;
    int unsigned        row_pos;
    int unsigned        col_pos;
    int unsigned        last_label;
    bit                 ovf;
    phase_e             scan;
    res_t               pending_labels[$];
    int unsigned        errors;

    function new();
      height_reg = 512;
      width_reg  = 1024;
      prev_cls   = '0;
      prev_lbl   = '0;
      row_pos    = 0;
      col_pos    = 0;
      last_label = 0;
      ovf        = 1'b0;
      scan       = PH_ORIGIN;
      errors     = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned m);
      if (v == 0) return 1;
      if (v > m) return m;
      return v;
    endfunction

    function int unsigned frame_rows();
      return clamp_size(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function int unsigned frame_cols();
      return clamp_size(width_reg, DEF_MAX_WIDTH);
    endfunction

    function void set_config(logic reg_idx, logic [31:0] value);
      if (reg_idx == REG_HEIGHT) begin
        height_reg = 32'(value[HCFG_W-1:0]);
      end else begin
        width_reg = 32'(value[WCFG_W-1:0]);
      end
    endfunction

    // saturate at the top of the label space and raise the sticky flag
    function logic [LABEL_W-1:0] take_label(output bit fresh);
      if (last_label < DEF_MAX_LABELS - 1) begin
        last_label++;
        fresh = 1'b1;
      end else begin
        last_label = DEF_MAX_LABELS - 1;
        ovf = 1'b1;
        fresh = 1'b0;
      end
      return LABEL_W'(last_label);
    endfunction

    function void note_pixel(logic [CLASS_W-1:0] cls);
      int unsigned        h, w, x, y;
      logic [LABEL_W-1:0] lbl, nlbl, left_lbl, up_lbl;
      logic [CLASS_W-1:0] ncls, left_cls, up_cls;
      bit                 fresh, ml, mt, fend;
      res_t               r;
      h = frame_rows();
      w = frame_cols();
      x = col_pos;
      y = row_pos;
      r = '0;
      fresh = 1'b0;
      fend = 1'b0;
      case (scan)
        PH_ORIGIN: begin
          last_label = 0;
          ovf = 1'b0;
          lbl = take_label(fresh);
          top_cls[0] = cls;
          top_lbl[0] = lbl;
          col_cls[0] = cls;
          col_lbl[0] = lbl;
        end
        PH_ROW0: begin
          if (cls == prev_cls) lbl = prev_lbl;
          else lbl = take_label(fresh);
          top_cls[x] = cls;
          top_lbl[x] = lbl;
        end
        PH_COL0: begin
          if (y == 1) begin
            ncls = top_cls[0];
            nlbl = top_lbl[0];
          end else begin
            ncls = prev_cls;
            nlbl = prev_lbl;
          end
          if (cls == ncls) lbl = nlbl;
          else lbl = take_label(fresh);
          col_cls[y] = cls;
          col_lbl[y] = lbl;
        end
        default: begin
          left_cls = col_cls[y];
          left_lbl = col_lbl[y];
          if (y == 1) begin
            up_cls = top_cls[x];
            up_lbl = top_lbl[x];
          end else begin
            up_cls = prev_cls;
            up_lbl = prev_lbl;
          end
          ml = (cls == left_cls);
          mt = (cls == up_cls);
          if (ml && mt) begin
            if (left_lbl == up_lbl) begin
              lbl = up_lbl;
            end else begin
              lbl = (left_lbl < up_lbl) ? left_lbl : up_lbl;
              r.merge_valid = 1'b1;
              r.merge_from  = (left_lbl < up_lbl) ? up_lbl : left_lbl;
              r.merge_to    = lbl;
            end
          end else if (ml) begin
            lbl = left_lbl;
          end else if (mt) begin
            lbl = up_lbl;
          end else begin
            lbl = take_label(fresh);
          end
          col_cls[y] = cls;
          col_lbl[y] = lbl;
        end
      endcase
      prev_cls = cls;
      prev_lbl = lbl;

      // advance along the visit order
      case (scan)
        PH_ORIGIN: begin
          if (w > 1) begin
            scan = PH_ROW0;
            col_pos = 1;
            row_pos = 0;
          end else if (h > 1) begin
            scan = PH_COL0;
            col_pos = 0;
            row_pos = 1;
          end else begin
            fend = 1'b1;
          end
        end
        PH_ROW0: begin
          if (x + 1 < w) begin
            col_pos = x + 1;
          end else if (h > 1) begin
            scan = PH_COL0;
            col_pos = 0;
            row_pos = 1;
          end else begin
            fend = 1'b1;
          end
        end
        PH_COL0: begin
          if (y + 1 < h) begin
            row_pos = y + 1;
          end else if (w > 1) begin
            scan = PH_INNER;
            col_pos = 1;
            row_pos = 1;
          end else begin
            fend = 1'b1;
          end
        end
        default: begin
          if (y + 1 < h) begin
            row_pos = y + 1;
          end else if (x + 1 < w) begin
            col_pos = x + 1;
            row_pos = 1;
          end else begin
            fend = 1'b1;
          end
        end
      endcase
      if (fend) begin
        scan = PH_ORIGIN;
        row_pos = 0;
        col_pos = 0;
      end

      r.pixel_label    = lbl;
      r.new_label      = fresh;
      r.label_count    = LABEL_W'(last_label);
      r.label_overflow = ovf;
      r.frame_end      = fend;
      pending_labels = {pending_labels, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_label(res_t got);
      res_t want;
      if (pending_labels.size() == 0) begin
        $error("pixel_label: expected none, got %0d", got.pixel_label);
        errors++;
        return;
      end
      want = pending_labels.pop_front();
      compare_field("pixel_label", 32'(want.pixel_label), 32'(got.pixel_label));
      compare_field("new_label", 32'(want.new_label), 32'(got.new_label));
      compare_field("merge_valid", 32'(want.merge_valid), 32'(got.merge_valid));
      compare_field("merge_from", 32'(want.merge_from), 32'(got.merge_from));
      compare_field("merge_to", 32'(want.merge_to), 32'(got.merge_to));
      compare_field("label_count", 32'(want.label_count), 32'(got.label_count));
      compare_field("label_overflow", 32'(want.label_overflow),
                    32'(got.label_overflow));
      compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
    endfunction

    function int unsigned pending();
      return pending_labels.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CLASS_W-1:0] pixel_class_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LABEL_W-1:0] pixel_label_o;
  logic               new_label_o;
  logic               merge_valid_o;
  logic [LABEL_W-1:0] merge_from_o;
  logic [LABEL_W-1:0] merge_to_o;
  logic [LABEL_W-1:0] label_count_o;
  logic               label_overflow_o;
  logic               frame_end_o;

  label_scoreboard    sb = new();
  logic [CLASS_W-1:0] pixel_q[$];
  int unsigned        gap_pct = 0;
  int unsigned        stall_pct = 0;

  connected_component_label_pass i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_class_i    (pixel_class_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_label_o    (pixel_label_o),
    .new_label_o      (new_label_o),
    .merge_valid_o    (merge_valid_o),
    .merge_from_o     (merge_from_o),
    .merge_to_o       (merge_to_o),
    .label_count_o    (label_count_o),
    .label_overflow_o (label_overflow_o),
    .frame_end_o      (frame_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic pick_idle(int unsigned n);
    case (n % 4)
      0: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct = 52;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 52;
      end
      default: begin
        gap_pct = 9;
        stall_pct = 9;
      end
    endcase
  endtask

  // write one register, then read it back
  task automatic write_reg(logic reg_idx, logic [31:0] data);
    logic [31:0] want;
    want = (reg_idx == REG_HEIGHT) ? 32'(data[HCFG_W-1:0]) : 32'(data[WCFG_W-1:0]);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_config(reg_idx, data);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare_field((reg_idx == REG_HEIGHT) ? "image_height readback" :
                     "image_width readback", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_size(logic [31:0] raw_h, logic [31:0] raw_w);
    wait_drained();
    write_reg(REG_HEIGHT, raw_h);
    write_reg(REG_WIDTH, raw_w);
  endtask

  // queue one frame in visit order; alpha 0 gives a pattern that never matches
  task automatic queue_frame(int unsigned alpha);
    int unsigned h, w;
    h = sb.frame_rows();
    w = sb.frame_cols();
    for (int unsigned n = 0; n < h * w; n++) begin
      int unsigned x, y;
      if (n == 0) begin
        x = 0;
        y = 0;
      end else if (n < w) begin
        x = n;
        y = 0;
      end else if (n < w + h - 1) begin
        x = 0;
        y = n - w + 1;
      end else begin
        x = 1 + (n - w - h + 1) / (h - 1);
        y = 1 + (n - w - h + 1) % (h - 1);
      end
      if (alpha == 0) pixel_q = {pixel_q, CLASS_W'(x + 2 * y)};
      else pixel_q = {pixel_q, CLASS_W'($urandom_range(alpha - 1, 0))};
    end
  endtask

  task automatic drive_pixels();
    while (pixel_q.size() != 0) begin
      if ($urandom_range(99, 0) < gap_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        in_valid_i <= 1'b1;
        pixel_class_i <= pixel_q[0];
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        sb.note_pixel(pixel_q.pop_front());
      end
    end
  endtask

  initial begin
    res_t seen;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen.pixel_label    = pixel_label_o;
        seen.new_label      = new_label_o;
        seen.merge_valid    = merge_valid_o;
        seen.merge_from     = merge_from_o;
        seen.merge_to       = merge_to_o;
        seen.label_count    = label_count_o;
        seen.label_overflow = label_overflow_o;
        seen.frame_end      = frame_end_o;
        sb.check_label(seen);
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned h, w, alpha, random_items, frame_no;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel frames
    pick_idle(0);
    apply_size(1, 1);
    pixel_q = {pixel_q, 8'h00};
    drive_pixels();
    pixel_q = {pixel_q, 8'hFF};
    drive_pixels();

    // 2x2: merge of two labels, then all same class
    pick_idle(1);
    apply_size(2, 2);
    pixel_q = '{8'd5, 8'd7, 8'd7, 8'd7, 8'd9, 8'd9, 8'd9, 8'd9};
    drive_pixels();

    // zero sizes fall back to one
    pick_idle(2);
    apply_size(32'hFFFF_FC00, 3);
    pixel_q = '{8'd1, 8'd1, 8'd2};
    drive_pixels();
    pick_idle(3);
    apply_size(3, 32'hFFFF_F800);
    pixel_q = '{8'd4, 8'd4, 8'd8};
    drive_pixels();
    pick_idle(0);
    apply_size(3, 3);
    queue_frame(256);
    drive_pixels();

    // size extremes, oversized values saturate
    pick_idle(1);
    apply_size(512, 2);
    queue_frame(2);
    drive_pixels();
    pick_idle(2);
    apply_size(1023, 1);
    queue_frame(3);
    drive_pixels();
    pick_idle(3);
    apply_size(1, 1024);
    queue_frame(2);
    drive_pixels();
    pick_idle(0);
    apply_size(2, 2047);
    queue_frame(4);
    drive_pixels();

    // every pixel needs a new label: run past the end of the label space
    pick_idle(3);
    apply_size(64, 65);
    queue_frame(0);
    drive_pixels();

    random_items = 0;
    frame_no = 0;
    while (random_items < 1700) begin
      pick_idle(frame_no);
      if (frame_no == 0 || $urandom_range(1, 0) == 1) begin
        h = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 1) : $urandom_range(12, 1);
        w = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
        apply_size(($urandom() << HCFG_W) | h, ($urandom() << WCFG_W) | w);
      end
      case ($urandom_range(3, 0))
        0: alpha = 2;
        1: alpha = 3;
        2: alpha = 4;
        default: alpha = 256;
      endcase
      queue_frame(alpha);
      random_items += pixel_q.size();
      drive_pixels();
      frame_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- connected_component_label_pass.f -----
hdl/ccl_pkg.sv
hdl/ccl_ram.sv
hdl/ccl_scan.sv
hdl/ccl_label.sv
hdl/ccl_obuf.sv
hdl/connected_component_label_pass.sv
hdl/ccl_checker.sv
tb/sv/connected_component_label_pass_test.sv
